>>> sv/msht_pkg.sv
package msht_pkg;

   localparam int MAX_SENSORS = 8;
   localparam int TEMP_W = 12;
   localparam int CNT_W = $clog2(MAX_SENSORS + 1);
   localparam int SUM_W = TEMP_W + $clog2(MAX_SENSORS) + 1;
   localparam int DIV_STEPS = SUM_W;
   localparam int ITER_W = $clog2(DIV_STEPS + 1);

   localparam logic signed [TEMP_W-1:0] DISCONNECTED = -12'sd2032;

   localparam logic [1:0] MODE_MAX = 2'd1;
   localparam logic [1:0] MODE_MEAN = 2'd2;

   localparam logic [1:0] REG_MODE = 2'd0;
   localparam logic [1:0] REG_LOW = 2'd1;
   localparam logic [1:0] REG_HIGH = 2'd2;

   localparam logic [1:0] PH_START = 2'd0;
   localparam logic [1:0] PH_HEAT = 2'd1;
   localparam logic [1:0] PH_IDLE = 2'd2;
   localparam logic [1:0] PH_RESERVED = 2'd3;

   localparam logic [1:0] MODE_RESET = MODE_MAX;
   localparam logic signed [TEMP_W-1:0] LOW_RESET = 12'sd568;
   localparam logic signed [TEMP_W-1:0] HIGH_RESET = 12'sd632;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   typedef struct packed {
      logic                     started;
      logic signed [TEMP_W-1:0] max;
      logic signed [SUM_W-1:0]  sum;
      logic [CNT_W-1:0]         count;
   } acc_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

>>> sv/msht_accum.sv
module msht_accum
   import msht_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  logic signed [TEMP_W-1:0] reading,
   input  logic                     last,
   output acc_type                  acc
);

   acc_type          set_ff;
   logic [CNT_W-1:0] items_ff;
   logic [CNT_W-1:0] items_in;

   always_comb begin
      acc = set_ff;
      items_in = items_ff;
      if (items_ff < CNT_W'(MAX_SENSORS)) begin
         if (!set_ff.started || reading > set_ff.max) begin
            acc.max = reading;
         end
         acc.started = 1'b1;
         if (reading != DISCONNECTED) begin
            acc.sum = set_ff.sum + SUM_W'(reading);
            acc.count = set_ff.count + CNT_W'(1);
         end
         items_in = items_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_ff <= '0;
         items_ff <= '0;
      end else if (take) begin
         if (last) begin
            set_ff <= '0;
            items_ff <= '0;
         end else begin
            set_ff <= acc;
            items_ff <= items_in;
         end
      end
   end

endmodule

>>> sv/msht_div.sv
module msht_div
   import msht_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [SUM_W-1:0]  dividend,
   input  logic [CNT_W-1:0]         divisor,
   output div_stat_type             stat,
   output logic signed [TEMP_W-1:0] quotient
);

   logic              busy_ff;
   logic              done_ff;
   logic [ITER_W-1:0] iter_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  rem_in;
   logic [SUM_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  divisor_ff;
   logic              neg_ff;
   logic [CNT_W:0]    rem_sh;
   logic [CNT_W:0]    rem_sub;
   logic              fits;
   logic [SUM_W-1:0]  magnitude;
   logic [TEMP_W-1:0] quo_low;

   always_comb begin
      magnitude = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem_sh = {rem_ff, quo_ff[SUM_W-1]};
      rem_sub = rem_sh - {1'b0, divisor_ff};
      fits = rem_sh >= {1'b0, divisor_ff};
      rem_in = fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_low = quo_ff[TEMP_W-1:0];
      quotient = neg_ff ? TEMP_W'(-quo_low) : quo_low;
      stat.busy = busy_ff;
      stat.done = done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            iter_ff <= ITER_W'(DIV_STEPS);
         end else if (busy_ff) begin
            iter_ff <= iter_ff - ITER_W'(1);
            if (iter_ff == ITER_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= magnitude;
         divisor_ff <= divisor;
         neg_ff <= dividend[SUM_W-1];
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[SUM_W-2:0], fits};
      end
   end

endmodule

>>> sv/multi_sensor_hysteresis_thermostat_core.sv
// Multi-sensor hysteresis thermostat.
// The req channel carries one sensor reading per transaction in tdata[11:0]
// (signed 1/16 degree); req_tlast marks the final reading of a sensor set.
// A reading that does not end a set is absorbed into the accumulator, so such
// readings can follow back to back. When a set ends, the readings are
// combined by the mode register and the three-phase hysteresis controller
// updates; one rsp transaction then carries the result.
// A set that ends in maximum or hold mode goes to the emit state, where the
// result is loaded into the output register and rsp_tvalid rises; req_tready
// is low in that state. In mean mode one restoring divider forms the average
// one quotient bit per cycle before the emit state, and req_tready is low
// while the divider runs; a set with no connected reading skips the divider.
// The result sits in an output register, so readings of the next set are
// still taken while rsp_tready is low; only the end of the next set waits
// for that register to empty.
// Reset is synchronous and restores the registers to mode 1 and thresholds
// of 568 and 632, with the controller in its start phase.
module multi_sensor_hysteresis_thermostat_core
   import msht_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] reading, [15:12] zero
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] heater_on, [12:1] measured_temperature,
                                    // [14:13] control_phase, [15] no_valid_readings
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   state_type                state_ff, state_in;
   logic [1:0]               mode_ff;
   logic signed [TEMP_W-1:0] low_ff, high_ff;
   logic [1:0]               phase_ff, phase_in;
   logic signed [TEMP_W-1:0] held_ff, held_in;
   logic                     flag_ff, flag_in;
   logic                     rsp_valid_ff;
   logic [15:0]              rsp_data_ff;
   logic                     heater;
   logic                     take;
   logic                     div_start;
   logic                     emit;
   acc_type                  acc;
   div_stat_type             div_stat;
   logic signed [TEMP_W-1:0] quotient;

   assign req_tready = (state_ff == ST_IDLE);
   assign take = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   msht_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .reading (req_tdata[TEMP_W-1:0]),
      .last    (req_tlast),
      .acc     (acc)
   );

   msht_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc.sum),
      .divisor  (acc.count),
      .stat     (div_stat),
      .quotient (quotient)
   );

   always_comb begin
      state_in = state_ff;
      held_in = held_ff;
      flag_in = flag_ff;
      div_start = 1'b0;
      emit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && req_tlast) begin
               flag_in = 1'b0;
               state_in = ST_EMIT;
               if (mode_ff == MODE_MAX) begin
                  if (acc.started) begin
                     held_in = acc.max;
                  end
               end else if (mode_ff == MODE_MEAN) begin
                  if (acc.count != '0) begin
                     div_start = 1'b1;
                     state_in = ST_DIVIDE;
                  end else begin
                     flag_in = 1'b1;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               held_in = quotient;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      heater = 1'b0;
      phase_in = phase_ff;
      case (phase_ff)
         PH_START: phase_in = (held_ff < low_ff) ? PH_HEAT : PH_IDLE;
         PH_HEAT: begin
            heater = 1'b1;
            if (held_ff > high_ff) begin
               phase_in = PH_IDLE;
            end
         end
         PH_IDLE: begin
            if (held_ff < low_ff) begin
               phase_in = PH_HEAT;
            end
         end
         default: phase_in = phase_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff <= MODE_RESET;
         low_ff <= LOW_RESET;
         high_ff <= HIGH_RESET;
         phase_ff <= PH_START;
         held_ff <= '0;
         flag_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff <= held_in;
         flag_ff <= flag_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_MODE: mode_ff <= csr_wdata[1:0];
               REG_LOW:  low_ff <= csr_wdata;
               REG_HIGH: high_ff <= csr_wdata;
               default:  ;
            endcase
         end
         if (emit) begin
            phase_ff <= phase_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= {flag_ff, phase_in, held_ff, heater};
      end
   end

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_RESERVED)
      else $error("controller phase left the legal set");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result appeared without a finished set");

   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside the divide state");

   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> !take)
      else $error("reading taken while the divider runs");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import msht_pkg::*;

   localparam logic [1:0] MODE_HOLD = 2'd0;
   localparam logic [1:0] MODE_HOLD_ALT = 2'd3;
   localparam int IDLE_PERCENT = 37;
   localparam int SETTLE_CYCLES = 30;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct {
      bit                       heater;
      logic signed [TEMP_W-1:0] temp;
      logic [1:0]               phase;
      bit                       flag;
   } thermo_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = REG_MODE;
   logic [11:0] csr_wdata = '0;

   thermo_result_type pending_results[$];
   int err_count = 0;
   int cycle_count = 0;
   int rsp_hold = 0;
   int stall_len = 0;
   int stall_gen = 0;
   int stall_seen = 0;
   bit req_gaps = 1'b1;
   bit rsp_gaps = 1'b1;

   // Mirror of the controller state and registers.
   logic [1:0] cfg_mode = MODE_RESET;
   int         cfg_low = int'(LOW_RESET);
   int         cfg_high = int'(HIGH_RESET);
   logic [1:0] ctl_phase = PH_START;
   int         held_temp = 0;
   int         set_max = 0;
   int         set_sum = 0;
   int         conn_count = 0;
   bit         set_open = 1'b0;
   int         taken = 0;

   multi_sensor_hysteresis_thermostat_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void take_reading(input int rd, input bit last);
      thermo_result_type res;
      if (taken < MAX_SENSORS) begin
         if (!set_open || rd > set_max) set_max = rd;
         set_open = 1'b1;
         if (rd != int'(DISCONNECTED)) begin
            set_sum += rd;
            conn_count++;
         end
         taken++;
      end
      if (!last) return;
      res.flag = 1'b0;
      res.heater = 1'b0;
      if (cfg_mode == MODE_MAX) begin
         if (set_open) held_temp = set_max;
      end else if (cfg_mode == MODE_MEAN) begin
         if (conn_count != 0) held_temp = set_sum / conn_count;
         else res.flag = 1'b1;
      end
      case (ctl_phase)
         PH_START: begin
            ctl_phase = (held_temp < cfg_low) ? PH_HEAT : PH_IDLE;
         end
         PH_HEAT: begin
            res.heater = 1'b1;
            if (held_temp > cfg_high) ctl_phase = PH_IDLE;
         end
         PH_IDLE: begin
            if (held_temp < cfg_low) ctl_phase = PH_HEAT;
         end
         default: ;
      endcase
      res.temp = held_temp[TEMP_W-1:0];
      res.phase = ctl_phase;
      pending_results.push_back(res);
      set_max = 0;
      set_sum = 0;
      conn_count = 0;
      set_open = 1'b0;
      taken = 0;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      err_count++;
   endtask

   task automatic send_reading(input int rd, input bit last);
      while (req_gaps && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0000, rd[11:0]};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      take_reading(rd, last);
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [1:0] m, input int lo, input int hi);
      csr_we <= 1'b1;
      csr_index <= REG_MODE;
      csr_wdata <= {10'b0, m};
      @(posedge clock);
      csr_index <= REG_LOW;
      csr_wdata <= lo[11:0];
      @(posedge clock);
      csr_index <= REG_HIGH;
      csr_wdata <= hi[11:0];
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_mode = m;
      cfg_low = lo;
      cfg_high = hi;
   endtask

   function automatic int pick_reading();
      int sel, lo, hi;
      sel = $urandom_range(99);
      if (sel < 10) return int'(DISCONNECTED);
      if (sel < 18) return $urandom_range(1) ? 2047 : -2048;
      if (sel < 38) return int'($urandom_range(4095)) - 2048;
      lo = ((cfg_low < cfg_high) ? cfg_low : cfg_high) - 100;
      hi = ((cfg_low < cfg_high) ? cfg_high : cfg_low) + 100;
      if (lo < -2048) lo = -2048;
      if (hi > 2047) hi = 2047;
      if (lo > hi) lo = hi;
      return lo + int'($urandom_range(hi - lo));
   endfunction

   task automatic send_random_set(output int n);
      n = ($urandom_range(99) < 85) ? $urandom_range(8, 1) : $urandom_range(12, 9);
      for (int j = 0; j < n; j++) send_reading(pick_reading(), j == n - 1);
   endtask

   task automatic random_config();
      int lo;
      lo = int'($urandom_range(1100)) - 400;
      write_config(2'($urandom_range(3)), lo, lo + int'($urandom_range(250)));
   endtask

   task automatic test_default_config();
      send_reading(100, 1'b0);
      send_reading(-2048, 1'b0);
      send_reading(300, 1'b1);
      send_reading(2047, 1'b1);
      send_reading(int'(DISCONNECTED), 1'b0);
      send_reading(-2048, 1'b1);
      wait_drain();
   endtask

   task automatic test_mean_mode();
      write_config(MODE_MEAN, 568, 632);
      send_reading(-3, 1'b0);
      send_reading(-4, 1'b1);
      send_reading(int'(DISCONNECTED), 1'b0);
      send_reading(int'(DISCONNECTED), 1'b1);
      send_reading(int'(DISCONNECTED), 1'b0);
      send_reading(11, 1'b1);
      wait_drain();
   endtask

   task automatic test_sensor_overflow();
      repeat (MAX_SENSORS) send_reading(-2048, 1'b0);
      send_reading(2047, 1'b1);
      wait_drain();
   endtask

   task automatic test_hold_modes();
      write_config(MODE_HOLD, 568, 632);
      send_reading(5, 1'b1);
      wait_drain();
      write_config(MODE_HOLD_ALT, 568, 632);
      send_reading(-2048, 1'b1);
      wait_drain();
   endtask

   task automatic test_threshold_extremes();
      write_config(MODE_MAX, 2047, -2048);
      send_reading(0, 1'b1);
      wait_drain();
      write_config(MODE_MAX, -2048, 2047);
      send_reading(2047, 1'b1);
      wait_drain();
   endtask

   task automatic test_output_stall();
      write_config(MODE_MAX, 300, 500);
      stall_len = 400;
      stall_gen++;
      req_gaps = 1'b0;
      for (int k = 0; k < 30; k++) send_reading(pick_reading(), (k % 3) != 1);
      req_gaps = 1'b1;
      wait_drain();
   endtask

   task automatic test_sender_pause();
      int n;
      write_config(MODE_MEAN, 100, 400);
      repeat (8) begin
         send_random_set(n);
         wait_drain();
      end
   endtask

   task automatic test_no_idle();
      int n, sent;
      random_config();
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      sent = 0;
      while (sent < 200) begin
         send_random_set(n);
         sent += n;
      end
      wait_drain();
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
   endtask

   task automatic test_random_sets();
      int n, sent;
      for (int p = 0; p < 10; p++) begin
         if (p == 3) write_config(MODE_MEAN, -2048, 2047);
         else if (p == 6) write_config(MODE_MAX, 2047, -2048);
         else if (p == 8) write_config(MODE_MEAN, 2047, 2047);
         else random_config();
         sent = 0;
         while (sent < 160) begin
            send_random_set(n);
            sent += n;
         end
         wait_drain();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_seen != stall_gen) begin
         rsp_tready <= 1'b0;
         rsp_hold <= stall_len - 1;
         stall_seen <= stall_gen;
      end else if (rsp_hold != 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else if (rsp_gaps) begin
         rsp_tready <= ($urandom_range(99) >= IDLE_PERCENT);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      thermo_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result 0x%h", rsp_tdata));
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[0] !== want.heater)
               report_mismatch($sformatf("heater_on got %b want %b", rsp_tdata[0],
                                         want.heater));
            if (rsp_tdata[12:1] !== want.temp)
               report_mismatch($sformatf("temperature got %0d want %0d",
                                         $signed(rsp_tdata[12:1]), want.temp));
            if (rsp_tdata[14:13] !== want.phase)
               report_mismatch($sformatf("phase got %0d want %0d", rsp_tdata[14:13],
                                         want.phase));
            if (rsp_tdata[15] !== want.flag)
               report_mismatch($sformatf("no_valid_readings got %b want %b",
                                         rsp_tdata[15], want.flag));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_default_config();
      test_mean_mode();
      test_sensor_overflow();
      test_hold_modes();
      test_threshold_extremes();
      test_output_stall();
      test_sender_pause();
      test_no_idle();
      test_random_sets();
      wait_drain();
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> multi_sensor_hysteresis_thermostat_core.f
sv/msht_pkg.sv
sv/msht_accum.sv
sv/msht_div.sv
sv/multi_sensor_hysteresis_thermostat_core.sv
bench/tb.sv
